// ===== rtl/ffq_pkg.sv =====
// shared constants, codes, types and helper functions for the filtering fifo
`default_nettype none

package ffq_pkg;

    // queue geometry
    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // command codes
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_FILTER = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // filter relation codes
    localparam logic [1:0] REL_GE = 2'd0;
    localparam logic [1:0] REL_LE = 2'd1;
    localparam logic [1:0] REL_NE = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH,
        DP_EMPTY_RES,
        DP_PLAIN_RES,
        DP_CLEAR,
        DP_HEAD_READ,
        DP_POP,
        DP_PEEK,
        DP_FLT_START,
        DP_FLT_READ,
        DP_FLT_STEP
    } t_dp_op;

    // datapath status seen by the controller
    typedef struct packed {
        logic empty;
        logic walk_last;
    } t_dp_sts;

    // circular increment of a store index
    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] nxt;
        nxt = (idx == PTR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

    // filter predicate, signed compare against the threshold
    function automatic logic keep_word(
        input logic signed [WORD_WIDTH-1:0] w,
        input logic signed [WORD_WIDTH-1:0] thr,
        input logic [1:0]                   rel
    );
        logic k;
        unique case (rel)
            REL_GE:  k = (w >= thr);
            REL_LE:  k = (w <= thr);
            REL_NE:  k = (w != thr);
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fifo_queue_with_filter_core.sv =====
// top level of the filtering fifo: sequencer plus datapath
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  command  | start, busy                | i_cmd, i_value_in, i_relation
//  result   | o_done (one-cycle strobe)  | o_value_out, o_status, o_occupancy
//
// a transaction is taken at a rising edge with start high and busy low.
// push, clear, unknown commands and any command on an empty queue give the
// result in the cycle after acceptance with busy never raised.
// pop and peek pass through the head state: one registered read of the word store.
// filter walks the N stored words: a read state then a compare state per word.
// reset is synchronous, active low, and leaves the queue empty.
// results cannot be held off by the receiver.
`default_nettype none

module fifo_queue_with_filter_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [2:0]                            i_cmd,
    input  wire logic signed [ffq_pkg::WORD_WIDTH-1:0] i_value_in,
    input  wire logic [1:0]                            i_relation,
    output logic                                       o_done,
    output logic signed [ffq_pkg::WORD_WIDTH-1:0]      o_value_out,
    output logic [1:0]                                 o_status,
    output logic [ffq_pkg::CNT_W-1:0]                  o_occupancy
);
    import ffq_pkg::*;

    t_dp_op  w_op;
    t_dp_sts w_sts;

    // command sequencer
    ffq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_op    (w_op),
        .busy    (busy),
        .o_done  (o_done)
    );

    // storage and result datapath
    ffq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_value_in  (i_value_in),
        .i_relation  (i_relation),
        .o_sts       (w_sts),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

endmodule

`default_nettype wire

// ===== rtl/ffq_ctrl.sv =====
// command sequencer for the filtering fifo
`default_nettype none

module ffq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       i_cmd,
    input  wire ffq_pkg::t_dp_sts i_sts,
    output ffq_pkg::t_dp_op       o_op,
    output logic                  busy,
    output logic                  o_done
);
    import ffq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_FREAD,
        S_FSTEP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_done, n_done;
    logic   r_is_pop, n_is_pop;
    logic   w_accept;

    assign w_accept = start && !r_busy;

    // next state and datapath operation
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_is_pop = r_is_pop;
        o_op     = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority case (i_cmd)
                        CMD_PUSH: begin
                            o_op   = DP_PUSH;
                            n_done = 1'b1;
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_sts.empty) begin
                                o_op   = DP_EMPTY_RES;
                                n_done = 1'b1;
                            end else begin
                                o_op     = DP_HEAD_READ;
                                n_is_pop = (i_cmd == CMD_POP);
                                n_state  = S_HEAD;
                            end
                        end
                        CMD_CLEAR: begin
                            o_op   = i_sts.empty ? DP_EMPTY_RES : DP_CLEAR;
                            n_done = 1'b1;
                        end
                        CMD_FILTER: begin
                            if (i_sts.empty) begin
                                o_op   = DP_EMPTY_RES;
                                n_done = 1'b1;
                            end else begin
                                o_op    = DP_FLT_START;
                                n_state = S_FREAD;
                            end
                        end
                        default: begin
                            o_op   = DP_PLAIN_RES;
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                o_op    = r_is_pop ? DP_POP : DP_PEEK;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_FREAD: begin
                o_op    = DP_FLT_READ;
                n_state = S_FSTEP;
            end
            S_FSTEP: begin
                o_op = DP_FLT_STEP;
                if (i_sts.walk_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_is_pop <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != S_IDLE);
            r_done   <= n_done;
            r_is_pop <= n_is_pop;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

    // busy flag tracks the state register
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");

    // every result comes from an accepted transaction or a finishing state
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(w_accept) || $past(r_state == S_HEAD)
                           || $past(r_state == S_FSTEP)))
        else $error("result strobe without a transaction");

    // a filter read is always followed by its compare step
    a_fread_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FREAD |=> r_state == S_FSTEP)
        else $error("filter walk lost a step");

endmodule

`default_nettype wire

// ===== rtl/ffq_datapath.sv =====
// word store, pointers, filter compare and result registers
`default_nettype none

module ffq_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire ffq_pkg::t_dp_op                       i_op,
    input  wire logic signed [ffq_pkg::WORD_WIDTH-1:0] i_value_in,
    input  wire logic [1:0]                            i_relation,
    output ffq_pkg::t_dp_sts                           o_sts,
    output logic signed [ffq_pkg::WORD_WIDTH-1:0]      o_value_out,
    output logic [1:0]                                 o_status,
    output logic [ffq_pkg::CNT_W-1:0]                  o_occupancy
);
    import ffq_pkg::*;

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;
    logic [PTR_W-1:0]      r_rptr, r_wptr, r_src, r_dst;
    logic [CNT_W-1:0]      r_count, r_remain, r_kept;
    logic [WORD_WIDTH-1:0] r_thr;
    logic [1:0]            r_rel;
    logic [WORD_WIDTH-1:0] r_value_out;
    logic [1:0]            r_status;
    logic [CNT_W-1:0]      r_occupancy;

    logic             w_full;
    logic             w_keep;
    logic [PTR_W-1:0] w_dst_next;
    logic [CNT_W-1:0] w_kept_next;
    logic [PTR_W-1:0] w_rd_addr;

    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_keep      = keep_word(r_rdata, r_thr, r_rel);
    assign w_dst_next  = w_keep ? next_idx(r_dst) : r_dst;
    assign w_kept_next = w_keep ? r_kept + 1'b1 : r_kept;
    assign w_rd_addr   = (i_op == DP_FLT_READ) ? r_src : r_rptr;

    // word store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_op == DP_PUSH && !w_full) begin
            r_mem[r_wptr] <= i_value_in;
        end else if (i_op == DP_FLT_STEP && w_keep) begin
            r_mem[r_dst] <= r_rdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // pointers, count and filter walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr   <= '0;
            r_wptr   <= '0;
            r_count  <= '0;
            r_src    <= '0;
            r_dst    <= '0;
            r_remain <= '0;
            r_kept   <= '0;
        end else begin
            unique case (i_op)
                DP_PUSH: begin
                    if (!w_full) begin
                        r_wptr  <= next_idx(r_wptr);
                        r_count <= r_count + 1'b1;
                    end
                end
                DP_POP: begin
                    r_rptr  <= next_idx(r_rptr);
                    r_count <= r_count - 1'b1;
                end
                DP_CLEAR: begin
                    r_rptr  <= '0;
                    r_wptr  <= '0;
                    r_count <= '0;
                end
                DP_FLT_START: begin
                    r_src    <= r_rptr;
                    r_dst    <= r_rptr;
                    r_remain <= r_count;
                    r_kept   <= '0;
                end
                DP_FLT_READ: begin
                    r_src    <= next_idx(r_src);
                    r_remain <= r_remain - 1'b1;
                end
                DP_FLT_STEP: begin
                    r_dst  <= w_dst_next;
                    r_kept <= w_kept_next;
                    if (r_remain == '0) begin
                        r_wptr  <= w_dst_next;
                        r_count <= w_kept_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // filter threshold and relation, captured with the transaction
    always_ff @(posedge i_clk) begin
        if (i_op == DP_FLT_START) begin
            r_thr <= i_value_in;
            r_rel <= i_relation;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_PUSH: begin
                r_value_out <= '0;
                r_status    <= w_full ? ST_FULL : ST_OK;
                r_occupancy <= w_full ? r_count : r_count + 1'b1;
            end
            DP_EMPTY_RES: begin
                r_value_out <= '1;
                r_status    <= ST_EMPTY;
                r_occupancy <= r_count;
            end
            DP_PLAIN_RES: begin
                r_value_out <= '0;
                r_status    <= ST_OK;
                r_occupancy <= r_count;
            end
            DP_CLEAR: begin
                r_value_out <= WORD_WIDTH'(r_count);
                r_status    <= ST_OK;
                r_occupancy <= '0;
            end
            DP_POP: begin
                r_value_out <= r_rdata;
                r_status    <= ST_OK;
                r_occupancy <= r_count - 1'b1;
            end
            DP_PEEK: begin
                r_value_out <= r_rdata;
                r_status    <= ST_OK;
                r_occupancy <= r_count;
            end
            DP_FLT_STEP: begin
                r_value_out <= '0;
                r_status    <= ST_OK;
                r_occupancy <= w_kept_next;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.walk_last = (r_remain == '0);
    assign o_value_out     = r_value_out;
    assign o_status        = r_status;
    assign o_occupancy     = r_occupancy;

    // count never exceeds the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("stored count beyond depth");

    // a filter compare step always has a word behind it
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == DP_FLT_STEP |-> r_remain < r_count)
        else $error("filter walk past stored words");

    // survivors never outnumber the words already examined
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == DP_FLT_STEP |-> r_kept + r_remain < r_count)
        else $error("filter kept more words than it read");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the filtering fifo: queued command driver, result monitor, shadow queue
module testbench;
    import ffq_pkg::*;

    // codes the block treats as no-operation or keep-nothing
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [1:0] REL_NONE    = 2'd3;

    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 20;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int ITEMS_PER_PHASE = 500;

    typedef struct {
        logic [2:0]                   cmd;
        logic signed [WORD_WIDTH-1:0] value;
        logic [1:0]                   relation;
        int                           idle_pct;
        bit                           drain_first;
    } command_t;

    typedef struct {
        logic signed [WORD_WIDTH-1:0] value;
        logic [1:0]                   status;
        logic [CNT_W-1:0]             occupancy;
    } fifo_result_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [2:0]                    i_cmd = '0;
    logic signed [WORD_WIDTH-1:0]  i_value_in = '0;
    logic [1:0]                    i_relation = '0;
    logic                          o_done;
    logic signed [WORD_WIDTH-1:0]  o_value_out;
    logic [1:0]                    o_status;
    logic [CNT_W-1:0]              o_occupancy;

    command_t                      command_queue[$];
    fifo_result_t                  awaited_results[$];
    logic signed [WORD_WIDTH-1:0]  shadow_words[$];
    logic                          cmd_taken = 1'b0;
    int                            mismatch_count = 0;
    int                            cycle_count = 0;
    int                            gen_idle_pct = 0;
    bit                            gen_drain = 1'b0;

    fifo_queue_with_filter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_value_in  (i_value_in),
        .i_relation  (i_relation),
        .o_done      (o_done),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // apply one command to the shadow queue and return its result
    function automatic fifo_result_t apply_command(input logic [2:0] cmd,
                                                   input logic signed [WORD_WIDTH-1:0] arg,
                                                   input logic [1:0] rel);
        fifo_result_t                 res;
        logic signed [WORD_WIDTH-1:0] survivors[$];
        logic                         keep;
        res.value  = '0;
        res.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (shadow_words.size() >= DEPTH) res.status = ST_FULL;
            else shadow_words.push_back(arg);
        end else if (cmd inside {CMD_POP, CMD_PEEK, CMD_CLEAR, CMD_FILTER}
                     && shadow_words.size() == 0) begin
            res.value  = -1;
            res.status = ST_EMPTY;
        end else begin
            case (cmd)
                CMD_POP: res.value = shadow_words.pop_front();
                CMD_PEEK: res.value = shadow_words[0];
                CMD_CLEAR: begin
                    res.value = shadow_words.size();
                    shadow_words.delete();
                end
                CMD_FILTER: begin
                    // survivors keep their order
                    foreach (shadow_words[k]) begin
                        case (rel)
                            REL_GE:  keep = (shadow_words[k] >= arg);
                            REL_LE:  keep = (shadow_words[k] <= arg);
                            REL_NE:  keep = (shadow_words[k] != arg);
                            default: keep = 1'b0;
                        endcase
                        if (keep) survivors.push_back(shadow_words[k]);
                    end
                    shadow_words = survivors;
                end
                default: ;
            endcase
        end
        res.occupancy = CNT_W'(shadow_words.size());
        return res;
    endfunction

    // count a failure, report only the first few
    function automatic void report_mismatch(input string what,
                                            input logic [WORD_WIDTH-1:0] want,
                                            input logic [WORD_WIDTH-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected %0h, actual %0h", what, want, got);
    endfunction

    // word mix: full range, extremes, and a small band so thresholds hit stored words
    function automatic logic signed [WORD_WIDTH-1:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r < 4) return $urandom;
        if (r == 4) begin
            case ($urandom_range(3))
                0: return {1'b0, {(WORD_WIDTH-1){1'b1}}};
                1: return {1'b1, {(WORD_WIDTH-1){1'b0}}};
                2: return '0;
                default: return '1;
            endcase
        end
        return $signed($urandom_range(8)) - 4;
    endfunction

    task automatic add_command(input logic [2:0] cmd,
                               input logic signed [WORD_WIDTH-1:0] value,
                               input logic [1:0] rel);
        command_t c;
        c.cmd         = cmd;
        c.value       = value;
        c.relation    = rel;
        c.idle_pct    = gen_idle_pct;
        c.drain_first = gen_drain;
        gen_drain     = 1'b0;
        command_queue.push_back(c);
    endtask

    // one random command with a realistic mix
    task automatic add_random_command();
        int r;
        logic [1:0] rel;
        r   = $urandom_range(99);
        rel = ($urandom_range(19) == 0) ? REL_NONE : 2'($urandom_range(2));
        if (r < 40) add_command(CMD_PUSH, pick_word(), 2'($urandom_range(3)));
        else if (r < 62) add_command(CMD_POP, pick_word(), 2'($urandom_range(3)));
        else if (r < 72) add_command(CMD_PEEK, pick_word(), 2'($urandom_range(3)));
        else if (r < 76) add_command(CMD_CLEAR, pick_word(), 2'($urandom_range(3)));
        else if (r < 94) add_command(CMD_FILTER, pick_word(), rel);
        else add_command(3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)), pick_word(),
                         2'($urandom_range(3)));
    endtask

    // driver: present the next transaction at the falling edge, hold it until taken
    always @(negedge i_clk) begin : drive_commands
        command_t nxt;
        bit       go;
        go = 1'b0;
        if (i_rst_n && (!start || cmd_taken)) begin
            if (command_queue.size() != 0) begin
                nxt = command_queue[0];
                if (nxt.drain_first && awaited_results.size() != 0) go = 1'b0;
                else go = ($urandom_range(99) >= nxt.idle_pct);
            end
            if (go) begin
                nxt = command_queue.pop_front();
                i_cmd      <= nxt.cmd;
                i_value_in <= nxt.value;
                i_relation <= nxt.relation;
                start      <= 1'b1;
            end else begin
                // junk on the payload while idle
                i_cmd      <= 3'($urandom);
                i_value_in <= $urandom;
                i_relation <= 2'($urandom);
                start      <= 1'b0;
            end
        end
    end

    // monitor: check delivered results, then predict the transaction taken at this edge
    always @(posedge i_clk) begin : check_results
        fifo_result_t want;
        if (i_rst_n) begin
            if (o_done !== 1'b0) begin
                if (o_done !== 1'b1) begin
                    report_mismatch("done strobe unknown", 1, o_done);
                end else if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited", 0, o_value_out);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_value_out !== want.value)
                        report_mismatch("value_out", want.value, o_value_out);
                    if (o_status !== want.status)
                        report_mismatch("status", want.status, o_status);
                    if (o_occupancy !== want.occupancy)
                        report_mismatch("occupancy", want.occupancy, o_occupancy);
                end
            end
            if (start && busy === 1'b0)
                awaited_results.push_back(apply_command(i_cmd, i_value_in, i_relation));
        end
        cmd_taken <= i_rst_n && start && (busy === 1'b0);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int phase_idle[4];
        int count;
        int n;
        phase_idle = '{0, 59, 0, 38};

        // directed: empty queue cases first
        add_command(CMD_POP, 0, REL_GE);
        add_command(CMD_PEEK, 0, REL_GE);
        add_command(CMD_CLEAR, 0, REL_GE);
        add_command(CMD_FILTER, 0, REL_GE);
        add_command(CMD_SPARE_6, -1, REL_NONE);
        // extremes of the word
        add_command(CMD_PUSH, {1'b0, {(WORD_WIDTH-1){1'b1}}}, REL_GE);
        add_command(CMD_PUSH, {1'b1, {(WORD_WIDTH-1){1'b0}}}, REL_LE);
        add_command(CMD_PUSH, 0, REL_NE);
        add_command(CMD_PUSH, -1, REL_NONE);
        add_command(CMD_PUSH, 5, REL_GE);
        add_command(CMD_PEEK, 0, REL_GE);
        add_command(CMD_POP, 0, REL_GE);
        // every relation, then one that keeps nothing
        add_command(CMD_FILTER, 0, REL_NE);
        add_command(CMD_FILTER, -1, REL_LE);
        add_command(CMD_PUSH, 3, REL_GE);
        add_command(CMD_FILTER, -1, REL_GE);
        add_command(CMD_SPARE_5, 7, REL_GE);
        add_command(CMD_SPARE_7, -1, REL_NONE);
        add_command(CMD_FILTER, 0, REL_NONE);
        gen_drain = 1'b1;
        add_command(CMD_PUSH, 1, REL_GE);
        add_command(CMD_CLEAR, 0, REL_GE);
        add_command(CMD_PUSH, 2, REL_GE);
        add_command(CMD_POP, 0, REL_GE);

        // random phases, each opening with a pause until every awaited result is delivered
        foreach (phase_idle[p]) begin
            gen_idle_pct = phase_idle[p];
            gen_drain    = 1'b1;
            count        = 0;
            while (count < ITEMS_PER_PHASE) begin
                n = $urandom_range(99);
                if (n < 7) begin
                    // run toward full and past it
                    n = $urandom_range(12, 20);
                    repeat (n) add_command(CMD_PUSH, pick_word(), 2'($urandom));
                    count += n;
                end else if (n < 11) begin
                    // drain toward and past empty
                    n = $urandom_range(8, 18);
                    repeat (n) add_command(CMD_POP, pick_word(), 2'($urandom));
                    count += n;
                end else begin
                    add_random_command();
                    count++;
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the last transaction to be taken and answered
        while (command_queue.size() != 0 || start) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ffq_pkg.sv
rtl/ffq_ctrl.sv
rtl/ffq_datapath.sv
rtl/fifo_queue_with_filter_core.sv
bench/testbench.sv
